// ===== src/periodic_event_task_dispatcher_unit_defines.svh =====
// Assertion macros shared by the dispatcher RTL.
// Standalone header; no dependencies. Empty bodies under synthesis.
`ifndef PERIODIC_EVENT_TASK_DISPATCHER_UNIT_DEFINES_SVH
`define PERIODIC_EVENT_TASK_DISPATCHER_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
`define PETD_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("petd: assertion failed");
`define PETD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("petd: assertion failed");
`else
`define PETD_ASSERT(label, clk, rst_n, prop)
`define PETD_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ===== src/petd_pkg.sv =====
// Shared types and constants of the periodic/event task dispatcher.
// No dependencies.
package petd_pkg;

    localparam int TASK_SLOTS_DEF       = 8;
    localparam int EVENT_COUNT_BITS_DEF = 8;
    localparam int TIME_W               = 32;
    localparam int OP_W                 = 2;
    localparam int TASK_IDX_W           = 3;
    localparam int KIND_W               = 3;
    localparam int QUEUE_DEPTH          = 2;

    typedef enum logic [OP_W-1:0] {
        OP_ADD   = 2'd0,
        OP_START = 2'd1,
        OP_SWEEP = 2'd2,
        OP_EVENT = 2'd3
    } t_op;

    typedef enum logic [KIND_W-1:0] {
        KIND_ADDED    = 3'd0,
        KIND_REFUSED  = 3'd1,
        KIND_INIT     = 3'd2,
        KIND_PERIODIC = 3'd3,
        KIND_EVENT    = 3'd4,
        KIND_NOTHING  = 3'd5
    } t_kind;

    typedef struct packed {
        t_op                   op;
        logic [TIME_W-1:0]     now_ms;
        logic [TIME_W-1:0]     interval_ms;
        logic                  has_signal;
        logic [TASK_IDX_W-1:0] event_task;
    } t_cmd;

endpackage

// ===== src/petd_if.sv =====
// Request and result channel interfaces of the dispatcher.
// Depends on petd_pkg for field widths.
interface petd_req_if;
    logic                            valid;
    logic                            ready;
    logic [petd_pkg::OP_W-1:0]       op;
    logic [petd_pkg::TIME_W-1:0]     now_ms;
    logic [petd_pkg::TIME_W-1:0]     interval_ms;
    logic                            has_signal;
    logic [petd_pkg::TASK_IDX_W-1:0] event_task;

    modport source (output valid, op, now_ms, interval_ms, has_signal, event_task,
                    input ready);
    modport sink   (input valid, op, now_ms, interval_ms, has_signal, event_task,
                    output ready);
endinterface

interface petd_res_if;
    logic                            valid;
    logic                            ready;
    logic [petd_pkg::KIND_W-1:0]     kind;
    logic [petd_pkg::TASK_IDX_W-1:0] task_index;
    logic                            last;

    modport source (output valid, kind, task_index, last, input ready);
    modport sink   (input valid, kind, task_index, last, output ready);
endinterface

// ===== src/petd_front.sv =====
// Front end: takes requests, decodes the op and registers a command.
// Depends on petd_pkg and petd_if.
module petd_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    petd_req_if.sink        i_req,
    output logic            o_valid,
    output petd_pkg::t_cmd  o_cmd,
    input  logic            i_ready
);
    import petd_pkg::*;

    logic r_valid;
    t_cmd r_cmd;
    t_cmd n_cmd;
    logic take;

    assign i_req.ready = !r_valid || i_ready;
    assign take        = i_req.valid && i_req.ready;

    always_comb begin
        n_cmd.now_ms      = i_req.now_ms;
        n_cmd.interval_ms = i_req.interval_ms;
        n_cmd.has_signal  = i_req.has_signal;
        n_cmd.event_task  = i_req.event_task;
        unique case (i_req.op)
            OP_ADD:   n_cmd.op = OP_ADD;
            OP_START: n_cmd.op = OP_START;
            OP_SWEEP: n_cmd.op = OP_SWEEP;
            default:  n_cmd.op = OP_EVENT;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (take) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_cmd <= n_cmd;
        end
    end

    assign o_valid = r_valid;
    assign o_cmd   = r_cmd;

endmodule

// ===== src/petd_queue.sv =====
// Short command queue between front end and back end.
// Depends on petd_pkg.
module petd_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  petd_pkg::t_cmd  i_cmd,
    output logic            o_ready,
    output logic            o_valid,
    output petd_pkg::t_cmd  o_cmd,
    input  logic            i_ready
);
    import petd_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_cmd             r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wp;
    logic [PTR_W-1:0] r_rp;
    logic [CNT_W-1:0] r_count;
    logic             push;
    logic             pop;

    assign o_ready = r_count != CNT_W'(QUEUE_DEPTH);
    assign o_valid = r_count != '0;
    assign push    = i_valid && o_ready;
    assign pop     = o_valid && i_ready;
    assign o_cmd   = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            if (push) begin
                r_wp <= (r_wp == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wp + PTR_W'(1);
            end
            if (pop) begin
                r_rp <= (r_rp == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rp + PTR_W'(1);
            end
            if (push && !pop) begin
                r_count <= r_count + CNT_W'(1);
            end else if (pop && !push) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wp] <= i_cmd;
        end
    end

endmodule

// ===== src/petd_back.sv =====
// Back end: task table, start/sweep sequencer and result register.
// Depends on petd_pkg, petd_if and the assertion macro header.
`include "periodic_event_task_dispatcher_unit_defines.svh"

module petd_back #(
    parameter int TASK_SLOTS       = petd_pkg::TASK_SLOTS_DEF,
    parameter int EVENT_COUNT_BITS = petd_pkg::EVENT_COUNT_BITS_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_cmd_valid,
    input  petd_pkg::t_cmd  i_cmd,
    output logic            o_cmd_ready,
    petd_res_if.source      o_res
);
    import petd_pkg::*;

    localparam int IDX_W = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;
    localparam int CNT_W = $clog2(TASK_SLOTS + 1);
    localparam int EV_W  = (CNT_W > TASK_IDX_W) ? CNT_W : TASK_IDX_W;
    localparam int EC_W  = EVENT_COUNT_BITS;

    typedef enum logic [2:0] {
        S_IDLE   = 3'b001,
        S_SCAN   = 3'b010,
        S_FINISH = 3'b100
    } t_state;

    // task table
    logic [TIME_W-1:0] r_period [TASK_SLOTS];
    logic [TIME_W-1:0] r_due    [TASK_SLOTS];
    logic              r_sig    [TASK_SLOTS];
    logic [EC_W-1:0]   r_pend   [TASK_SLOTS];

    t_state             r_state,  n_state;
    logic               r_is_start, n_is_start;
    logic [TIME_W-1:0]  r_now,    n_now;
    logic [IDX_W-1:0]   r_idx,    n_idx;
    logic [CNT_W-1:0]   r_cnt,    n_cnt;
    logic               r_run,    n_run;
    logic               r_have,   n_have;
    t_kind              r_hkind,  n_hkind;
    logic [IDX_W-1:0]   r_hidx,   n_hidx;

    logic                  r_ovalid;
    t_kind                 r_okind;
    logic [TASK_IDX_W-1:0] r_oidx;
    logic                  r_olast;

    logic              out_can;
    logic              take;
    logic [IDX_W-1:0]  rd_idx;
    logic [TIME_W-1:0] rd_period;
    logic [TIME_W-1:0] rd_due;
    logic              rd_sig;
    logic [EC_W-1:0]   rd_pend;
    logic              ev_in_range;
    logic              due_hit;
    logic              ev_hit;
    logic              last_idx;
    logic              cand;
    t_kind             cand_kind;
    logic              scan_stall;
    logic [IDX_W-1:0]  add_wa;

    logic              emit;
    t_kind             e_kind;
    logic [IDX_W-1:0]  e_idx;
    logic              e_last;
    logic              add_we;
    logic              due_we;
    logic [TIME_W-1:0] due_wd;
    logic              pend_we;
    logic [IDX_W-1:0]  pend_wa;
    logic [EC_W-1:0]   pend_wd;

    assign out_can     = !r_ovalid || o_res.ready;
    assign o_cmd_ready = (r_state == S_IDLE) && out_can;
    assign take        = i_cmd_valid && o_cmd_ready;

    assign rd_idx    = (r_state == S_SCAN) ? r_idx : IDX_W'(i_cmd.event_task);
    assign rd_period = r_period[rd_idx];
    assign rd_due    = r_due[rd_idx];
    assign rd_sig    = r_sig[rd_idx];
    assign rd_pend   = r_pend[rd_idx];
    assign add_wa    = IDX_W'(r_cnt);

    assign ev_in_range = (EV_W'(i_cmd.event_task) < EV_W'(r_cnt))
                      && (EV_W'(i_cmd.event_task) < EV_W'(TASK_SLOTS));
    assign due_hit    = (rd_period != '0) && (rd_due <= r_now);
    assign ev_hit     = rd_sig && (rd_pend != '0);
    assign last_idx   = CNT_W'(r_idx) == (r_cnt - CNT_W'(1));
    assign cand       = r_is_start || due_hit || ev_hit;
    assign cand_kind  = r_is_start ? KIND_INIT : (due_hit ? KIND_PERIODIC : KIND_EVENT);
    assign scan_stall = cand && r_have && !out_can;

    always_comb begin
        n_state    = r_state;
        n_is_start = r_is_start;
        n_now      = r_now;
        n_idx      = r_idx;
        n_cnt      = r_cnt;
        n_run      = r_run;
        n_have     = r_have;
        n_hkind    = r_hkind;
        n_hidx     = r_hidx;
        emit       = 1'b0;
        e_kind     = KIND_NOTHING;
        e_idx      = '0;
        e_last     = 1'b0;
        add_we     = 1'b0;
        due_we     = 1'b0;
        due_wd     = r_now;
        pend_we    = 1'b0;
        pend_wa    = rd_idx;
        pend_wd    = rd_pend;
        unique case (r_state)
            S_IDLE: begin
                if (take) begin
                    unique case (i_cmd.op)
                        OP_ADD: begin
                            emit   = 1'b1;
                            e_last = 1'b1;
                            if (r_run || r_cnt == CNT_W'(TASK_SLOTS)) begin
                                e_kind = KIND_REFUSED;
                            end else begin
                                e_kind = KIND_ADDED;
                                e_idx  = add_wa;
                                add_we = 1'b1;
                                n_cnt  = r_cnt + CNT_W'(1);
                            end
                        end
                        OP_START, OP_SWEEP: begin
                            if (r_run == (i_cmd.op == OP_START)) begin
                                emit   = 1'b1;
                                e_last = 1'b1;
                            end else begin
                                n_run      = 1'b1;
                                n_is_start = i_cmd.op == OP_START;
                                n_now      = i_cmd.now_ms;
                                n_idx      = '0;
                                n_have     = 1'b0;
                                n_state    = (r_cnt == '0) ? S_FINISH : S_SCAN;
                            end
                        end
                        default: begin
                            emit   = 1'b1;
                            e_last = 1'b1;
                            if (ev_in_range && rd_sig && rd_pend != '1) begin
                                pend_we = 1'b1;
                                pend_wd = rd_pend + EC_W'(1);
                            end
                        end
                    endcase
                end
            end
            S_SCAN: begin
                if (!scan_stall) begin
                    if (cand) begin
                        if (r_have) begin
                            emit   = 1'b1;
                            e_kind = r_hkind;
                            e_idx  = r_hidx;
                        end
                        n_have  = 1'b1;
                        n_hkind = cand_kind;
                        n_hidx  = r_idx;
                    end
                    if (r_is_start) begin
                        due_we = 1'b1;
                    end else if (due_hit) begin
                        due_we = 1'b1;
                        due_wd = rd_due + rd_period;
                    end else if (ev_hit) begin
                        pend_we = 1'b1;
                        pend_wd = rd_pend - EC_W'(1);
                    end
                    if (last_idx) begin
                        n_state = S_FINISH;
                    end else begin
                        n_idx = r_idx + IDX_W'(1);
                    end
                end
            end
            S_FINISH: begin
                if (out_can) begin
                    emit    = 1'b1;
                    e_last  = 1'b1;
                    e_kind  = r_have ? r_hkind : KIND_NOTHING;
                    e_idx   = r_have ? r_hidx : '0;
                    n_have  = 1'b0;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_cnt    <= '0;
            r_run    <= 1'b0;
            r_have   <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_run   <= n_run;
            r_have  <= n_have;
            if (emit) begin
                r_ovalid <= 1'b1;
            end else if (o_res.ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_is_start <= n_is_start;
        r_now      <= n_now;
        r_idx      <= n_idx;
        r_hkind    <= n_hkind;
        r_hidx     <= n_hidx;
        if (emit) begin
            r_okind <= e_kind;
            r_oidx  <= TASK_IDX_W'(e_idx);
            r_olast <= e_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (add_we) begin
            r_period[add_wa] <= i_cmd.interval_ms;
            r_sig[add_wa]    <= i_cmd.has_signal;
            r_due[add_wa]    <= '0;
        end else if (due_we) begin
            r_due[r_idx] <= due_wd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < TASK_SLOTS; k++) begin
                r_pend[k] <= '0;
            end
        end else if (pend_we) begin
            r_pend[pend_wa] <= pend_wd;
        end
    end

    assign o_res.valid      = r_ovalid;
    assign o_res.kind       = r_okind;
    assign o_res.task_index = r_oidx;
    assign o_res.last       = r_olast;

    `PETD_ASSERT(a_cnt_bound, i_clk, i_rst_n, r_cnt <= CNT_W'(TASK_SLOTS))
    `PETD_ASSERT(a_scan_idx, i_clk, i_rst_n, (r_state == S_SCAN) |-> (CNT_W'(r_idx) < r_cnt))
    `PETD_ASSERT(a_busy_running, i_clk, i_rst_n, (r_state != S_IDLE) |-> r_run)
    `PETD_ASSERT(a_idle_no_held, i_clk, i_rst_n, (r_state == S_IDLE) |-> !r_have)
    `PETD_ASSERT_NEXT(a_table_frozen, i_clk, i_rst_n, r_run, r_cnt == $past(r_cnt))

endmodule

// ===== src/periodic_event_task_dispatcher_unit.sv =====
// Periodic/event task dispatcher. Each request is registered by the front end and queued
// (two entries) for the back end, which owns the task table. Add and event requests give
// one result. Start and sweep walk the table one task per cycle, unless a held result is
// waiting on the output, through a single table read port, then close the request in
// S_FINISH: one result per task that inits or runs, the last one flagged, or a single
// "nothing" result. Results leave through a one-entry output register; while a result
// waits, up to three more requests are taken in.
// Depends on petd_pkg, petd_if, petd_front, petd_queue and petd_back.
module periodic_event_task_dispatcher_unit #(
    parameter int TASK_SLOTS       = petd_pkg::TASK_SLOTS_DEF,
    parameter int EVENT_COUNT_BITS = petd_pkg::EVENT_COUNT_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    petd_req_if.sink    i_req,
    petd_res_if.source  o_res
);
    import petd_pkg::*;

    logic f_valid;
    t_cmd f_cmd;
    logic f_ready;
    logic q_valid;
    t_cmd q_cmd;
    logic q_ready;

    petd_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (i_req),
        .o_valid (f_valid),
        .o_cmd   (f_cmd),
        .i_ready (f_ready)
    );

    petd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (f_valid),
        .i_cmd   (f_cmd),
        .o_ready (f_ready),
        .o_valid (q_valid),
        .o_cmd   (q_cmd),
        .i_ready (q_ready)
    );

    petd_back #(
        .TASK_SLOTS       (TASK_SLOTS),
        .EVENT_COUNT_BITS (EVENT_COUNT_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (q_valid),
        .i_cmd       (q_cmd),
        .o_cmd_ready (q_ready),
        .o_res       (o_res)
    );

endmodule

// ===== dv/petd_dispatch_checker.sv =====
`timescale 1ns / 1ps
// Dispatcher scoreboard: keeps its own copy of the task table, predicts the results of
// every accepted request and checks returned results in order. Depends on petd_pkg, petd_if.
module petd_dispatch_checker (
    input  logic i_clk,
    input  logic i_rst_n,
    petd_req_if  i_req,
    petd_res_if  i_res,
    output int   o_fail_count,
    output int   o_outstanding
);
    import petd_pkg::*;

    typedef struct packed {
        t_kind                 kind;
        logic [TASK_IDX_W-1:0] task_index;
        logic                  last;
    } t_outcome;

    logic [TIME_W-1:0]               period_tbl [TASK_SLOTS_DEF];
    logic [TIME_W-1:0]               due_tbl    [TASK_SLOTS_DEF];
    logic                            sig_tbl    [TASK_SLOTS_DEF];
    logic [EVENT_COUNT_BITS_DEF-1:0] event_cnt  [TASK_SLOTS_DEF];
    int                              tasks_added;
    bit                              started;
    t_outcome                        outcome_q [$];
    t_outcome                        exp_r;
    int                              fails = 0;

    task automatic dispatch_request(input t_op op, input logic [TIME_W-1:0] now,
                                    input logic [TIME_W-1:0] period, input logic sig,
                                    input logic [TASK_IDX_W-1:0] evt);
        t_outcome made [$];
        t_outcome entry;
        int       i;
        made = {};
        case (op)
            OP_ADD: begin
                if (started || tasks_added >= TASK_SLOTS_DEF) begin
                    made.push_back('{KIND_REFUSED, '0, 1'b0});
                end else begin
                    period_tbl[tasks_added] = period;
                    due_tbl[tasks_added]    = '0;
                    sig_tbl[tasks_added]    = sig;
                    made.push_back('{KIND_ADDED, TASK_IDX_W'(tasks_added), 1'b0});
                    tasks_added++;
                end
            end
            OP_START: begin
                if (!started) begin
                    started = 1'b1;
                    for (i = 0; i < tasks_added; i++) begin
                        due_tbl[i] = now;
                        made.push_back('{KIND_INIT, TASK_IDX_W'(i), 1'b0});
                    end
                end
            end
            OP_SWEEP: begin
                if (started) begin
                    for (i = 0; i < tasks_added; i++) begin
                        if (period_tbl[i] != '0 && due_tbl[i] <= now) begin
                            due_tbl[i] = due_tbl[i] + period_tbl[i];
                            made.push_back('{KIND_PERIODIC, TASK_IDX_W'(i), 1'b0});
                        end else if (sig_tbl[i] && event_cnt[i] != '0) begin
                            event_cnt[i] = event_cnt[i] - 1'b1;
                            made.push_back('{KIND_EVENT, TASK_IDX_W'(i), 1'b0});
                        end
                    end
                end
            end
            default: begin
                if (int'(evt) < tasks_added && sig_tbl[evt] && event_cnt[evt] != '1) begin
                    event_cnt[evt] = event_cnt[evt] + 1'b1;
                end
            end
        endcase
        if (made.size() == 0) begin
            made.push_back('{KIND_NOTHING, '0, 1'b0});
        end
        for (i = 0; i < made.size(); i++) begin
            entry      = made[i];
            entry.last = (i == made.size() - 1);
            outcome_q.push_back(entry);
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            tasks_added = 0;
            started     = 1'b0;
            for (int i = 0; i < TASK_SLOTS_DEF; i++) begin
                event_cnt[i] = '0;
            end
            outcome_q.delete();
        end else begin
            if (i_req.valid && i_req.ready) begin
                dispatch_request(t_op'(i_req.op), i_req.now_ms, i_req.interval_ms,
                                 i_req.has_signal, i_req.event_task);
            end
            if (i_res.valid && i_res.ready) begin
                if (outcome_q.size() == 0) begin
                    $error("unexpected result: kind %0d task_index %0d last %0d",
                           i_res.kind, i_res.task_index, i_res.last);
                    fails++;
                end else begin
                    exp_r = outcome_q.pop_front();
                    if (i_res.kind !== exp_r.kind) begin
                        $error("kind: expected %0d, got %0d", exp_r.kind, i_res.kind);
                        fails++;
                    end
                    if (i_res.task_index !== exp_r.task_index) begin
                        $error("task_index: expected %0d, got %0d",
                               exp_r.task_index, i_res.task_index);
                        fails++;
                    end
                    if (i_res.last !== exp_r.last) begin
                        $error("last: expected %0d, got %0d", exp_r.last, i_res.last);
                        fails++;
                    end
                end
            end
        end
        o_fail_count  = fails;
        o_outstanding = outcome_q.size();
    end

endmodule

// ===== dv/tb_periodic_event_task_dispatcher_unit.sv =====
`timescale 1ns / 1ps
// Testbench top for the task dispatcher: drives request traffic and result backpressure,
// and reports the verdict. Depends on petd_pkg, petd_if, petd_dispatch_checker and the dispatcher unit.
module tb_periodic_event_task_dispatcher_unit;
    import petd_pkg::*;

    localparam int          LONG_HOLD    = 300;
    localparam int          PILE_EVENTS  = 12;
    localparam int          RANDOM_ITEMS = 72;
    localparam int          QUIET_ITEMS  = 20;
    localparam int          SETTLE       = 40;
    localparam int unsigned CYCLE_LIMIT  = 400000;

    logic              clk;
    logic              rst_n;
    bit                quiet_tail;
    bit                hold_go;
    bit                hold_done;
    logic [TIME_W-1:0] clock_ms;
    int                fail_count;
    int                outstanding;
    int unsigned       cycles = 0;

    petd_req_if req_ch ();
    petd_res_if res_ch ();

    periodic_event_task_dispatcher_unit DUT (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_req   (req_ch),
        .o_res   (res_ch)
    );

    petd_dispatch_checker u_dispatch_checker (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_req         (req_ch),
        .i_res         (res_ch),
        .o_fail_count  (fail_count),
        .o_outstanding (outstanding)
    );

    initial begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // called at a falling edge, returns at the falling edge after acceptance
    task automatic send_req(input t_op op, input logic [TIME_W-1:0] now,
                            input logic [TIME_W-1:0] period, input logic sig,
                            input logic [TASK_IDX_W-1:0] evt);
        int gap;
        if (!quiet_tail && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 16);
            req_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        req_ch.valid       <= 1'b1;
        req_ch.op          <= op;
        req_ch.now_ms      <= now;
        req_ch.interval_ms <= period;
        req_ch.has_signal  <= sig;
        req_ch.event_task  <= evt;
        do begin
            @(posedge clk);
        end while (!req_ch.ready);
        @(negedge clk);
    endtask

    task automatic send_random();
        int                pick;
        t_op               op;
        logic [TIME_W-1:0] now;
        pick = $urandom_range(0, 99);
        if (pick < 45) begin
            op = OP_SWEEP;
        end else if (pick < 85) begin
            op = OP_EVENT;
        end else if (pick < 93) begin
            op = OP_ADD;
        end else begin
            op = OP_START;
        end
        pick = $urandom_range(0, 19);
        if (pick == 0) begin
            now = $urandom;
        end else if (pick == 1) begin
            now = '1;
        end else begin
            clock_ms = clock_ms + $urandom_range(0, 30);
            now      = clock_ms;
        end
        send_req(op, now, $urandom, 1'($urandom_range(0, 1)),
                 TASK_IDX_W'($urandom_range(0, 7)));
    endtask

    task automatic drain();
        req_ch.valid <= 1'b0;
        while (outstanding != 0) @(negedge clk);
    endtask

    initial begin
        int gap;
        res_ch.ready = 1'b0;
        hold_done    = 1'b0;
        wait (rst_n === 1'b1);
        forever begin
            @(negedge clk);
            if (hold_go && !hold_done) begin
                res_ch.ready <= 1'b0;
                repeat (LONG_HOLD - 1) @(negedge clk);
                hold_done = 1'b1;
            end else if (!quiet_tail && $urandom_range(0, 5) == 0) begin
                gap = $urandom_range(1, 16);
                res_ch.ready <= 1'b0;
                repeat (gap - 1) @(negedge clk);
            end else begin
                res_ch.ready <= 1'b1;
            end
        end
    end

    initial begin
        int n;
        req_ch.valid       = 1'b0;
        req_ch.op          = OP_ADD;
        req_ch.now_ms      = '0;
        req_ch.interval_ms = '0;
        req_ch.has_signal  = 1'b0;
        req_ch.event_task  = '0;
        rst_n              = 1'b0;
        quiet_tail         = 1'b0;
        hold_go            = 1'b0;
        clock_ms           = 32'hFFFF_FFF0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // table setup, ignored requests before start
        send_req(OP_SWEEP, '0, $urandom, 1'b0, 3'd0);
        send_req(OP_EVENT, $urandom, $urandom, 1'b1, 3'd0);
        send_req(OP_ADD, $urandom, 32'd0, 1'b1, 3'd0);
        send_req(OP_ADD, $urandom, 32'd3, 1'b1, 3'd7);
        send_req(OP_EVENT, $urandom, $urandom, 1'b0, 3'd5);
        send_req(OP_ADD, $urandom, 32'hFFFF_FFFF, 1'b0, 3'd0);
        send_req(OP_EVENT, $urandom, $urandom, 1'b1, 3'd2);
        send_req(OP_ADD, $urandom, 32'd7, 1'b1, 3'd0);
        send_req(OP_ADD, $urandom, 32'd0, 1'b0, 3'd0);
        send_req(OP_ADD, $urandom, 32'd1, 1'b1, 3'd0);
        send_req(OP_ADD, $urandom, 32'd20, 1'b1, 3'd0);
        send_req(OP_ADD, $urandom, 32'd100, 1'b0, 3'd0);
        send_req(OP_ADD, $urandom, $urandom, 1'b1, 3'd0);
        send_req(OP_SWEEP, 32'hFFFF_FFFF, $urandom, 1'b0, 3'd0);

        // start, then requests against a running table
        send_req(OP_START, 32'hFFFF_FFF0, $urandom, 1'b0, 3'd0);
        send_req(OP_START, '0, $urandom, 1'b1, 3'd0);
        send_req(OP_ADD, $urandom, 32'd5, 1'b1, 3'd0);
        send_req(OP_SWEEP, 32'hFFFF_FF00, $urandom, 1'b0, 3'd0);
        send_req(OP_EVENT, $urandom, $urandom, 1'b0, 3'd7);
        send_req(OP_EVENT, $urandom, $urandom, 1'b0, 3'd0);
        send_req(OP_EVENT, $urandom, $urandom, 1'b1, 3'd0);
        send_req(OP_EVENT, $urandom, $urandom, 1'b0, 3'd3);
        send_req(OP_SWEEP, '0, $urandom, 1'b0, 3'd0);
        send_req(OP_SWEEP, 32'hFFFF_FFF0, $urandom, 1'b0, 3'd0);
        send_req(OP_SWEEP, 32'hFFFF_FFFF, $urandom, 1'b0, 3'd0);

        // pile events on one task
        for (n = 0; n < PILE_EVENTS; n++) begin
            send_req(OP_EVENT, $urandom, $urandom, 1'($urandom_range(0, 1)), 3'd6);
        end
        send_req(OP_SWEEP, 32'hFFFF_FFFF, $urandom, 1'b0, 3'd0);
        drain();

        hold_go = 1'b1;
        for (n = 0; n < RANDOM_ITEMS; n++) begin
            if (n == RANDOM_ITEMS - QUIET_ITEMS) quiet_tail = 1'b1;
            send_random();
        end
        drain();
        repeat (SETTLE) @(posedge clk);

        if (fail_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+src
src/petd_pkg.sv
src/petd_if.sv
src/petd_front.sv
src/petd_queue.sv
src/petd_back.sv
src/periodic_event_task_dispatcher_unit.sv
dv/petd_dispatch_checker.sv
dv/tb_periodic_event_task_dispatcher_unit.sv
